/* hw/rtl/aarm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle to matrix block
// Holds the transaction payload structs, the CORDIC cell data struct, the
// arctangent table and the output rounding and saturation function.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_COUNT       = 24;
    localparam int FRAC_BITS        = 14;
    localparam int TRIG_BITS        = 30;
    localparam int XW               = 34;    // CORDIC x, y, z width
    localparam int PQW              = 32;    // axis product width
    localparam int PW               = PQW + XW;
    localparam int UW               = 52;    // accumulated entry width

    localparam logic signed [XW-1:0] INV_GAIN_Q30 = XW'(652032874);
    localparam logic signed [XW-1:0] ONE_Q30      = XW'(1) <<< TRIG_BITS;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] angle;
    } axis_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic               flip;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } cordic_t;

    // Arctangent of 2^-i in units of 2^32 per full turn.
    function automatic logic signed [XW-1:0] atan_lut(input int i);
        logic signed [XW-1:0] v;
        case (i)
            0:       v = XW'(536870912);
            1:       v = XW'(316933406);
            2:       v = XW'(167458907);
            3:       v = XW'(85004756);
            4:       v = XW'(42667331);
            5:       v = XW'(21354465);
            6:       v = XW'(10679838);
            7:       v = XW'(5340245);
            8:       v = XW'(2670163);
            9:       v = XW'(1335087);
            10:      v = XW'(667544);
            11:      v = XW'(333772);
            12:      v = XW'(166886);
            13:      v = XW'(83443);
            14:      v = XW'(41722);
            15:      v = XW'(20861);
            16:      v = XW'(10430);
            17:      v = XW'(5215);
            18:      v = XW'(2608);
            19:      v = XW'(1304);
            20:      v = XW'(652);
            21:      v = XW'(326);
            22:      v = XW'(163);
            23:      v = XW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Adds the two terms, rounds away the Q30 fraction and saturates to 16 bits.
    function automatic logic signed [15:0] finish(input logic signed [UW-1:0] t,
                                                  input logic signed [UW-1:0] a);
        logic signed [UW-1:0]           u;
        logic signed [UW-TRIG_BITS-1:0] r;
        logic signed [15:0]             o;
        u = t + a + (UW'(1) <<< (TRIG_BITS - 1));
        r = u[UW-1:TRIG_BITS];
        if (r > (UW-TRIG_BITS)'(32767)) begin
            o = 16'sh7fff;
        end else if (r < -(UW-TRIG_BITS)'(32768)) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

endpackage

/* hw/rtl/aarm_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic_cell: one rotation-mode CORDIC step
// Performs the micro-rotation for a fixed step index and hands the result,
// together with the axis, to the next cell.
// ----------------------------------------------------------------------------
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    prev_valid,
    input  cordic_t prev,
    output logic    valid,
    output cordic_t data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    always_comb
    begin
        data_next = prev;
        if (prev.z >= 0) begin
            data_next.x = prev.x - (prev.y >>> STEP);
            data_next.y = prev.y + (prev.x >>> STEP);
            data_next.z = prev.z - atan_lut(STEP);
        end else begin
            data_next.x = prev.x + (prev.y >>> STEP);
            data_next.y = prev.y - (prev.x >>> STEP);
            data_next.z = prev.z + atan_lut(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hw/rtl/aarm_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_matrix: Rodrigues matrix assembly
// Four pipeline stages turn cosine, sine and axis into the nine rounded and
// saturated matrix entries. The last stage is the output register.
// ----------------------------------------------------------------------------
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    prev_valid,
    input  cordic_t prev,
    output logic    valid,
    output mat_t    data
);

    localparam int XX = 0;
    localparam int XY = 1;
    localparam int XZ = 2;
    localparam int YY = 3;
    localparam int YZ = 4;
    localparam int ZZ = 5;
    localparam logic signed [PW-1:0] ROUND_T = PW'(1) <<< (FRAC_BITS - 1);

    // Stage 1: cosine, sine, 1 - cosine and axis products.
    logic                  s1_valid_reg;
    logic signed [XW-1:0]  s1_c_reg, s1_s_reg, s1_mc_reg;
    logic signed [PQW-1:0] s1_pq_reg [6];
    logic signed [15:0]    s1_ax_reg, s1_ay_reg, s1_az_reg;

    // Stage 2: full products.
    logic                  s2_valid_reg;
    logic signed [PW-1:0]  s2_pm_reg [6];
    logic signed [UW-1:0]  s2_xs_reg, s2_ys_reg, s2_zs_reg, s2_cd_reg;

    // Stage 3: rounded outer terms.
    logic                  s3_valid_reg;
    logic signed [UW-1:0]  s3_t_reg [6];
    logic signed [UW-1:0]  s3_xs_reg, s3_ys_reg, s3_zs_reg, s3_cd_reg;

    // Stage 4: output register.
    logic                  s4_valid_reg;
    mat_t                  s4_data_reg;
    mat_t                  s4_data_next;

    always_comb
    begin
        s4_data_next.m00 = finish(s3_t_reg[XX], s3_cd_reg);
        s4_data_next.m01 = finish(s3_t_reg[XY], -s3_zs_reg);
        s4_data_next.m02 = finish(s3_t_reg[XZ], s3_ys_reg);
        s4_data_next.m10 = finish(s3_t_reg[XY], s3_zs_reg);
        s4_data_next.m11 = finish(s3_t_reg[YY], s3_cd_reg);
        s4_data_next.m12 = finish(s3_t_reg[YZ], -s3_xs_reg);
        s4_data_next.m20 = finish(s3_t_reg[XZ], -s3_ys_reg);
        s4_data_next.m21 = finish(s3_t_reg[YZ], s3_xs_reg);
        s4_data_next.m22 = finish(s3_t_reg[ZZ], s3_cd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= prev_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_c_reg      <= prev.flip ? -prev.x : prev.x;
            s1_s_reg      <= prev.flip ? -prev.y : prev.y;
            s1_mc_reg     <= prev.flip ? ONE_Q30 + prev.x : ONE_Q30 - prev.x;
            s1_pq_reg[XX] <= PQW'(prev.ax) * PQW'(prev.ax);
            s1_pq_reg[XY] <= PQW'(prev.ax) * PQW'(prev.ay);
            s1_pq_reg[XZ] <= PQW'(prev.ax) * PQW'(prev.az);
            s1_pq_reg[YY] <= PQW'(prev.ay) * PQW'(prev.ay);
            s1_pq_reg[YZ] <= PQW'(prev.ay) * PQW'(prev.az);
            s1_pq_reg[ZZ] <= PQW'(prev.az) * PQW'(prev.az);
            s1_ax_reg     <= prev.ax;
            s1_ay_reg     <= prev.ay;
            s1_az_reg     <= prev.az;

            for (int k = 0; k < 6; k++) begin
                s2_pm_reg[k] <= PW'(s1_pq_reg[k]) * PW'(s1_mc_reg);
            end
            s2_xs_reg <= UW'(s1_ax_reg) * UW'(s1_s_reg);
            s2_ys_reg <= UW'(s1_ay_reg) * UW'(s1_s_reg);
            s2_zs_reg <= UW'(s1_az_reg) * UW'(s1_s_reg);
            s2_cd_reg <= UW'(s1_c_reg) <<< FRAC_BITS;

            for (int k = 0; k < 6; k++) begin
                s3_t_reg[k] <= UW'((s2_pm_reg[k] + ROUND_T) >>> FRAC_BITS);
            end
            s3_xs_reg <= s2_xs_reg;
            s3_ys_reg <= s2_ys_reg;
            s3_zs_reg <= s2_zs_reg;
            s3_cd_reg <= s2_cd_reg;

            s4_data_reg <= s4_data_next;
        end
    end

    assign valid = s4_valid_reg;
    assign data  = s4_data_reg;

endmodule

/* hw/rtl/axis_angle_to_rotation_matrix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_top: axis-angle to 3x3 rotation matrix
// Computes cosine and sine of the angle with a chain of CORDIC cells and
// builds the Rodrigues rotation matrix in Q2.14 with rounding and saturation.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                              | Transaction
//   --------+------------------------------------+---------------------------
//   input   | axis_valid, axis_stall, axis_data  | axis x, y, z and angle
//   output  | mat_valid, mat_stall, mat_data     | nine matrix entries
//
// One transaction enters per cycle while axis_stall is low and passes in turn
// through each CORDIC cell and then the four matrix assembly stages.
// The whole pipeline advances together; it holds only while a finished
// result sits in the output register and the consumer stalls it, and then
// axis_stall is raised in the same cycle. Reset clears only the valid bits
// of the cells and stages; no transaction is lost or repeated on a stall.
//
module axis_angle_to_rotation_matrix_top
    import aarm_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  axis_valid,
    output logic  axis_stall,
    input  axis_t axis_data,
    output logic  mat_valid,
    input  logic  mat_stall,
    output mat_t  mat_data
);

    localparam int NCELL = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

    logic               en;
    logic signed [16:0] ang_wide;
    logic signed [16:0] ang_fold;
    cordic_t            head;
    logic               cell_valid [NCELL];
    cordic_t            cell_data  [NCELL];

    // The pipeline moves whenever the output register is empty or being taken.
    assign en         = !mat_valid || !mat_stall;
    assign axis_stall = !en;

    // Fold angles beyond a quarter turn by half a turn so the CORDIC sees
    // only [-pi/2, pi/2]; cosine and sine are negated at the end instead.
    always_comb
    begin
        ang_wide  = 17'(axis_data.angle);
        head.flip = (ang_wide > 17'sd16384) || (ang_wide < -17'sd16384);
        if (ang_wide > 17'sd16384) begin
            ang_fold = ang_wide - 17'sd32768;
        end else if (ang_wide < -17'sd16384) begin
            ang_fold = ang_wide + 17'sd32768;
        end else begin
            ang_fold = ang_wide;
        end
        head.x  = INV_GAIN_Q30;
        head.y  = '0;
        head.z  = XW'(ang_fold) <<< 16;
        head.ax = axis_data.axis_x;
        head.ay = axis_data.axis_y;
        head.az = axis_data.axis_z;
    end

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        if (i == 0) begin : g_first
            aarm_cordic_cell #(.STEP(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .prev_valid (axis_valid),
                .prev       (head),
                .valid      (cell_valid[i]),
                .data       (cell_data[i])
            );
        end else begin : g_next
            aarm_cordic_cell #(.STEP(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .prev_valid (cell_valid[i-1]),
                .prev       (cell_data[i-1]),
                .valid      (cell_valid[i]),
                .data       (cell_data[i])
            );
        end
    end

    aarm_matrix u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prev_valid (cell_valid[NCELL-1]),
        .prev       (cell_data[NCELL-1]),
        .valid      (mat_valid),
        .data       (mat_data)
    );

`ifndef ASSERT_OFF
    // A held result must hold back the whole pipeline.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_stall |-> axis_stall)
        else $error("output held but input not stalled");

    // A new result can only appear if the pipeline was advancing when it was loaded.
    a_load_moves: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mat_valid) |-> $past(!axis_stall))
        else $error("result appeared without pipeline advance");

    // The last cell only hands over a transaction when the pipeline advances.
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        axis_stall |=> $stable(cell_valid[NCELL-1]))
        else $error("cell chain moved during a stall");
`endif

endmodule
